FILE: hw/rtl/buffer_pool_frame_manager_top_defines.svh
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_top_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_FRAME_MANAGER_TOP_DEFINES_SVH
`define BUFFER_POOL_FRAME_MANAGER_TOP_DEFINES_SVH

// check once reset has been released
`define BPFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check during reset as well
`define BPFM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared constants, opcodes and command types of the frame manager.
// ----------------------------------------------------------------------------
package bpfm_pkg;

	localparam int FRAMES    = 16;
	localparam int PIN_MAX   = 255;
	localparam int FIDX_W    = $clog2(FRAMES);
	localparam int LEN_W     = $clog2(FRAMES + 1);
	localparam int PIN_W     = $clog2(PIN_MAX + 1);
	localparam int PAGE_W    = 31;
	localparam int IDX_OUT_W = 4;

	typedef enum logic [1:0] {
		OP_PIN   = 2'd0,
		OP_UNPIN = 2'd1,
		OP_FLUSH = 2'd2,
		OP_FREE  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic load;
		logic inc;
		logic dec;
		logic dirty_val;
	} frame_cmd_t;

	typedef struct packed {
		logic rm_en;
		logic push_head;
		logic push_tail;
	} list_cmd_t;

endpackage

FILE: hw/rtl/bpfm_frame_cell.sv
// ----------------------------------------------------------------------------
// bpfm_frame_cell
// One page frame: tag, valid, pin count, dirty; passes first-hit and
// first-free search marks on to the next frame.
// ----------------------------------------------------------------------------
module bpfm_frame_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bpfm_pkg::PAGE_W-1:0] page,
	input  logic                       sel,
	input  bpfm_pkg::frame_cmd_t       cmd,
	input  logic                       hit_in,
	input  logic                       free_in,
	output logic                       hit_out,
	output logic                       free_out,
	output logic                       hit_first,
	output logic                       free_first,
	output logic [bpfm_pkg::PAGE_W-1:0] tag,
	output logic                       valid,
	output logic [bpfm_pkg::PIN_W-1:0]  pin,
	output logic                       dirty
);
	import bpfm_pkg::*;

	logic [PAGE_W-1:0] tag_q;
	logic              valid_q;
	logic [PIN_W-1:0]  pin_q;
	logic              dirty_q;
	logic              match;
	logic              is_free;

	assign match      = valid_q && (tag_q == page);
	assign is_free    = !valid_q && (pin_q == '0) && !dirty_q;
	assign hit_first  = match && !hit_in;
	assign free_first = is_free && !free_in;
	assign hit_out    = hit_in || match;
	assign free_out   = free_in || is_free;
	assign tag        = tag_q;
	assign valid      = valid_q;
	assign pin        = pin_q;
	assign dirty      = dirty_q;

	always_ff @(posedge clk) begin
		if (sel && cmd.load) begin
			tag_q <= page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pin_q   <= '0;
			dirty_q <= 1'b0;
		end else if (sel) begin
			if (cmd.load) begin
				valid_q <= 1'b1;
				pin_q   <= PIN_W'(1);
				dirty_q <= 1'b0;
			end else if (cmd.inc) begin
				pin_q <= pin_q + PIN_W'(1);
			end else if (cmd.dec) begin
				pin_q   <= pin_q - PIN_W'(1);
				dirty_q <= cmd.dirty_val;
			end
		end
	end

endmodule

FILE: hw/rtl/bpfm_list_cell.sv
// ----------------------------------------------------------------------------
// bpfm_list_cell
// One slot of a candidate list; shifts towards the head on removal and
// towards the tail on a head push.
// ----------------------------------------------------------------------------
module bpfm_list_cell (
	input  logic                       clk,
	input  bpfm_pkg::list_cmd_t        cmd,
	input  logic                       active,
	input  logic                       tail_here,
	input  logic [bpfm_pkg::FIDX_W-1:0] rm_val,
	input  logic [bpfm_pkg::FIDX_W-1:0] push_val,
	input  logic [bpfm_pkg::FIDX_W-1:0] prev_entry,
	input  logic [bpfm_pkg::FIDX_W-1:0] next_entry,
	input  logic                       seen_in,
	output logic                       seen_out,
	output logic [bpfm_pkg::FIDX_W-1:0] entry
);
	import bpfm_pkg::*;

	logic [FIDX_W-1:0] entry_q;

	assign seen_out = seen_in || (cmd.rm_en && active && (entry_q == rm_val));
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.rm_en && seen_out) begin
			entry_q <= next_entry;
		end else if (cmd.push_head) begin
			entry_q <= prev_entry;
		end else if (cmd.push_tail && tail_here) begin
			entry_q <= push_val;
		end
	end

endmodule

FILE: hw/rtl/buffer_pool_frame_manager_top.sv
// The result word is registered after the lookup and execute steps.
// An unpin that drops the pin count to zero queues the frame in an extra push step.
// A new word is taken only in idle, after lookup, execute and any list push step.
// A result waiting on the output holds the execute step.
// Reset: arst_n clears valid, pin and dirty bits, list lengths and the sequencer.
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_top
// Buffer pool frame manager with pin counts, a hated MRU stack and a
// loved LRU queue, built as rows of frame cells and list slot cells.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  opcode,
	input  logic [bpfm_pkg::PAGE_W-1:0] page_id,
	input  logic                        skip_read,
	input  logic                        mark_dirty,
	input  logic                        hate_hint,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic [bpfm_pkg::IDX_OUT_W-1:0] frame_index,
	output logic                        write_back,
	output logic [bpfm_pkg::PAGE_W-1:0] write_page_id,
	output logic                        read_in,
	output logic                        deallocate
);
	import bpfm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_EXEC = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

	state_t state_q;

	logic [1:0]        op_q;
	logic [PAGE_W-1:0] page_q;
	logic              skip_q;
	logic              mdirty_q;
	logic              hate_q;
	logic              hit_q;
	logic [FIDX_W-1:0] f_q;
	logic              free_ok_q;
	logic [FIDX_W-1:0] free_idx_q;
	logic [LEN_W-1:0]  hlen_q;
	logic [LEN_W-1:0]  llen_q;

	logic              out_valid_q;
	logic              status_q;
	logic [FIDX_W-1:0] idx_q;
	logic              wb_q;
	logic [PAGE_W-1:0] wpage_q;
	logic              rd_q;
	logic              dealloc_q;

	logic [PAGE_W-1:0] fr_tag   [FRAMES];
	logic              fr_valid [FRAMES];
	logic [PIN_W-1:0]  fr_pin   [FRAMES];
	logic              fr_dirty [FRAMES];
	logic [FRAMES:0]   hit_chain;
	logic [FRAMES:0]   free_chain;
	logic [FRAMES-1:0] hit_oh;
	logic [FRAMES-1:0] free_oh;
	logic [FIDX_W-1:0] hit_idx;
	logic [FIDX_W-1:0] free_idx;

	logic [FIDX_W-1:0] h_entry [FRAMES];
	logic [FIDX_W-1:0] l_entry [FRAMES];
	logic [FRAMES:0]   h_seen;
	logic [FRAMES:0]   l_seen;

	frame_cmd_t        fcmd;
	logic [FIDX_W-1:0] ftgt;
	list_cmd_t         hcmd;
	list_cmd_t         lcmd;
	logic [FIDX_W-1:0] h_rm;
	logic [FIDX_W-1:0] l_rm;

	logic              out_free;
	logic              go;
	logic              fail;
	logic [FIDX_W-1:0] idx;
	logic              wb;
	logic [PAGE_W-1:0] wpage;
	logic              rd;
	logic              dealloc;
	logic              need_push;
	logic [FIDX_W-1:0] v;

	assign in_ready      = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || out_ready;
	assign go            = (state_q == S_EXEC) && out_free;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign frame_index   = IDX_OUT_W'(idx_q);
	assign write_back    = wb_q;
	assign write_page_id = wpage_q;
	assign read_in       = rd_q;
	assign deallocate    = dealloc_q;

	assign hit_chain[0]  = 1'b0;
	assign free_chain[0] = 1'b0;
	assign h_seen[0]     = 1'b0;
	assign l_seen[0]     = 1'b0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_frame
		bpfm_frame_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.page       (page_q),
			.sel        (ftgt == FIDX_W'(i)),
			.cmd        (fcmd),
			.hit_in     (hit_chain[i]),
			.free_in    (free_chain[i]),
			.hit_out    (hit_chain[i+1]),
			.free_out   (free_chain[i+1]),
			.hit_first  (hit_oh[i]),
			.free_first (free_oh[i]),
			.tag        (fr_tag[i]),
			.valid      (fr_valid[i]),
			.pin        (fr_pin[i]),
			.dirty      (fr_dirty[i])
		);
	end

	for (genvar i = 0; i < FRAMES; i++) begin : g_list
		bpfm_list_cell u_hated (
			.clk        (clk),
			.cmd        (hcmd),
			.active     (LEN_W'(i) < hlen_q),
			.tail_here  (LEN_W'(i) == hlen_q),
			.rm_val     (h_rm),
			.push_val   (f_q),
			.prev_entry ((i == 0) ? f_q : h_entry[(i == 0) ? 0 : i-1]),
			.next_entry ((i == FRAMES-1) ? h_entry[i] : h_entry[(i == FRAMES-1) ? i : i+1]),
			.seen_in    (h_seen[i]),
			.seen_out   (h_seen[i+1]),
			.entry      (h_entry[i])
		);
		bpfm_list_cell u_loved (
			.clk        (clk),
			.cmd        (lcmd),
			.active     (LEN_W'(i) < llen_q),
			.tail_here  (LEN_W'(i) == llen_q),
			.rm_val     (l_rm),
			.push_val   (f_q),
			.prev_entry ((i == 0) ? f_q : l_entry[(i == 0) ? 0 : i-1]),
			.next_entry ((i == FRAMES-1) ? l_entry[i] : l_entry[(i == FRAMES-1) ? i : i+1]),
			.seen_in    (l_seen[i]),
			.seen_out   (l_seen[i+1]),
			.entry      (l_entry[i])
		);
	end

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (hit_oh[i]) hit_idx = hit_idx | FIDX_W'(i);
			if (free_oh[i]) free_idx = free_idx | FIDX_W'(i);
		end
	end

	always_comb begin
		fail      = 1'b0;
		idx       = '0;
		wb        = 1'b0;
		wpage     = '0;
		rd        = 1'b0;
		dealloc   = 1'b0;
		need_push = 1'b0;
		v         = free_idx_q;
		fcmd      = '0;
		ftgt      = f_q;
		hcmd      = '0;
		lcmd      = '0;
		h_rm      = f_q;
		l_rm      = f_q;
		case (opcode_t'(op_q))
			OP_PIN: begin
				if (hit_q) begin
					if (fr_pin[f_q] == PIN_W'(PIN_MAX)) begin
						fail = 1'b1;
					end else begin
						fcmd.inc   = 1'b1;
						hcmd.rm_en = 1'b1;
						lcmd.rm_en = 1'b1;
						idx        = f_q;
					end
				end else begin
					if (hlen_q != '0) begin
						v          = h_entry[0];
						h_rm       = h_entry[0];
						hcmd.rm_en = 1'b1;
					end else if (llen_q != '0) begin
						v          = l_entry[0];
						l_rm       = l_entry[0];
						lcmd.rm_en = 1'b1;
					end else if (!free_ok_q) begin
						fail = 1'b1;
					end
					if (!fail) begin
						wb        = fr_valid[v] && fr_dirty[v];
						wpage     = wb ? fr_tag[v] : '0;
						rd        = !skip_q;
						fcmd.load = 1'b1;
						ftgt      = v;
						idx       = v;
					end
				end
			end
			OP_UNPIN: begin
				if (!hit_q || fr_pin[f_q] == '0) begin
					fail = 1'b1;
				end else begin
					fcmd.dec       = 1'b1;
					fcmd.dirty_val = mdirty_q;
					idx            = f_q;
					if (fr_pin[f_q] == PIN_W'(1)) begin
						hcmd.rm_en = 1'b1;
						lcmd.rm_en = 1'b1;
						need_push  = 1'b1;
					end
				end
			end
			OP_FLUSH: begin
				if (!hit_q) begin
					fail = 1'b1;
				end else begin
					wb    = 1'b1;
					wpage = page_q;
					idx   = f_q;
				end
			end
			default: begin
				if (!hit_q || fr_pin[f_q] != '0) begin
					fail = 1'b1;
				end else begin
					dealloc = fr_dirty[f_q];
					idx     = f_q;
				end
			end
		endcase
		if (!go) begin
			fcmd = '0;
			hcmd = '0;
			lcmd = '0;
		end
		if (state_q == S_PUSH) begin
			hcmd.push_head = hate_q && (hlen_q < LEN_W'(FRAMES));
			lcmd.push_tail = !hate_q && (llen_q < LEN_W'(FRAMES));
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= opcode;
			page_q   <= page_id;
			skip_q   <= skip_read;
			mdirty_q <= mark_dirty;
			hate_q   <= hate_hint;
		end
		if (state_q == S_LOOK) begin
			hit_q      <= hit_chain[FRAMES];
			f_q        <= hit_idx;
			free_ok_q  <= free_chain[FRAMES];
			free_idx_q <= free_idx;
		end
		if (go) begin
			status_q  <= fail;
			idx_q     <= idx;
			wb_q      <= wb;
			wpage_q   <= wpage;
			rd_q      <= rd;
			dealloc_q <= dealloc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			hlen_q      <= '0;
			llen_q      <= '0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (hcmd.rm_en && h_seen[FRAMES]) begin
				hlen_q <= hlen_q - LEN_W'(1);
			end else if (hcmd.push_head) begin
				hlen_q <= hlen_q + LEN_W'(1);
			end
			if (lcmd.rm_en && l_seen[FRAMES]) begin
				llen_q <= llen_q - LEN_W'(1);
			end else if (lcmd.push_tail) begin
				llen_q <= llen_q + LEN_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= need_push ? S_PUSH : S_IDLE;
					end
				end
				S_PUSH: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/bpfm_checker.sv
// ----------------------------------------------------------------------------
// bpfm_checker
// Port-level checks of the frame manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "buffer_pool_frame_manager_top_defines.svh"

module bpfm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        status,
	input logic [bpfm_pkg::IDX_OUT_W-1:0] frame_index,
	input logic                        write_back,
	input logic [bpfm_pkg::PAGE_W-1:0] write_page_id,
	input logic                        read_in,
	input logic                        deallocate
);

	`BPFM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_index), "result word dropped or changed while stalled")
	`BPFM_ASSERT(a_fail_zero, out_valid && status |-> frame_index == '0 && !write_back && !read_in && !deallocate, "failed result carries non-zero fields")
	`BPFM_ASSERT(a_wpage_zero, out_valid && !write_back |-> write_page_id == '0, "write page set without write back")
	`BPFM_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "new word taken while previous one in work")
	`BPFM_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result word present during reset")

endmodule

bind buffer_pool_frame_manager_top bpfm_checker u_bpfm_checker (.*);
